// ----- rtl/dilp_pkg.sv -----
// Package: transaction types and character constants for the decimal list parser.
package dilp_pkg;

    localparam int MAG_W = 31;
    localparam int NUM_W = 32;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [3:0] RADIX = 4'd10;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] number;
        logic                    number_valid;
        logic                    end_of_list;
    } out_item_t;

endpackage

// ----- rtl/dilp_scan.sv -----
// Scanner state machine: per-byte token phase, digit accumulation and result build.
module dilp_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  dilp_pkg::in_item_t  item,
    output logic                res_valid,
    output dilp_pkg::out_item_t res
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    localparam int ACC_W = dilp_pkg::MAG_W + 4;

    phase_t                     phase_reg, phase_next;
    logic [dilp_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic                       minus_reg, minus_next;

    logic                       is_digit, is_blank, is_comma;
    logic [3:0]                 digit;
    logic [7:0]                 digit_full;
    logic [ACC_W-1:0]           acc_ext, acc;
    logic [dilp_pkg::MAG_W-1:0] acc_sat;
    logic                       have;
    logic                       use_next;
    logic [dilp_pkg::MAG_W-1:0] out_mag;
    logic                       out_minus;
    logic [dilp_pkg::NUM_W-1:0] out_pos;

    always_comb
    begin
        is_digit   = (item.text_byte >= dilp_pkg::CHAR_ZERO) &&
                     (item.text_byte <= dilp_pkg::CHAR_NINE);
        is_blank   = (item.text_byte == dilp_pkg::CHAR_SPACE) ||
                     ((item.text_byte >= dilp_pkg::CHAR_TAB) &&
                      (item.text_byte <= dilp_pkg::CHAR_CR));
        is_comma   = (item.text_byte == dilp_pkg::CHAR_COMMA);
        digit_full = item.text_byte - dilp_pkg::CHAR_ZERO;
        digit      = digit_full[3:0];

        // mag * 10 + digit as shift-add
        acc_ext = {4'b0000, mag_reg};
        acc     = (acc_ext << 3) + (acc_ext << 1) + {{(ACC_W-4){1'b0}}, digit};
        acc_sat = (acc > {4'b0000, dilp_pkg::MAG_MAX}) ? dilp_pkg::MAG_MAX
                                                       : acc[dilp_pkg::MAG_W-1:0];

        phase_next = phase_reg;
        mag_next   = mag_reg;
        minus_next = minus_reg;
        have       = 1'b0;

        unique case (phase_reg)
            PH_IDLE, PH_DIGITS:
            begin
                if ((phase_reg == PH_DIGITS) && is_digit)
                begin
                    mag_next = acc_sat;
                end
                else
                begin
                    have = (phase_reg == PH_DIGITS);
                    if (is_blank || is_comma)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (item.text_byte == dilp_pkg::CHAR_MINUS)
                    begin
                        minus_next = 1'b1;
                        mag_next   = '0;
                        phase_next = PH_SIGN;
                    end
                    else if (item.text_byte == dilp_pkg::CHAR_PLUS)
                    begin
                        minus_next = 1'b0;
                        mag_next   = '0;
                        phase_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        minus_next = 1'b0;
                        mag_next   = {{(dilp_pkg::MAG_W-4){1'b0}}, digit};
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SIGN:
            begin
                if (is_digit)
                begin
                    mag_next   = {{(dilp_pkg::MAG_W-4){1'b0}}, digit};
                    phase_next = PH_DIGITS;
                end
                else if (is_comma)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (is_comma)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // final byte closes a number still open after this byte
        use_next = !have && item.final_byte && (phase_next == PH_DIGITS);
        out_mag   = use_next ? mag_next : mag_reg;
        out_minus = use_next ? minus_next : minus_reg;
        out_pos   = {1'b0, out_mag};

        res_valid        = have || item.final_byte;
        res.number_valid = have || use_next;
        res.end_of_list  = item.final_byte;
        if (have || use_next)
        begin
            res.number = out_minus ? $signed(-out_pos) : $signed(out_pos);
        end
        else
        begin
            res.number = '0;
        end

        if (item.final_byte)
        begin
            phase_next = PH_IDLE;
            mag_next   = '0;
            minus_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            mag_reg   <= '0;
            minus_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            minus_reg <= minus_next;
        end
    end

endmodule

// ----- rtl/decimal_integer_list_parser.sv -----
// Throughput: one byte per cycle unless result_stall holds a full output register.
// The scanner updates its phase and magnitude (shift-add times ten with saturation)
// combinationally between the input and output registers.
// Bytes that close no number and are not final produce no transaction.
// Reset (rst_n low, asynchronous): input and output registers empty, scanner between tokens.
module decimal_integer_list_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  dilp_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output dilp_pkg::out_item_t result_item
);

    logic                in_valid_reg;
    dilp_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    dilp_pkg::out_item_t out_item_reg;

    logic                fire;
    logic                res_valid;
    dilp_pkg::out_item_t res;

    assign fire         = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall   = in_valid_reg && !fire;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    dilp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_item_reg <= byte_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_item_reg <= res;
        end
    end

endmodule

// ----- rtl/dilp_checker.sv -----
// Port checker for the decimal list parser, bound to the top level.
module dilp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_stall,
    input logic                result_valid,
    input logic                result_stall,
    input dilp_pkg::out_item_t result_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result transaction changed");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.number_valid |-> result_item.end_of_list)
        else $error("result transaction without number and without end of list");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.number_valid |-> result_item.number == 32'sd0)
        else $error("result transaction without number carries nonzero value");

    a_no_min_int: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_item.number != 32'sh8000_0000)
        else $error("number outside saturated range");

    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && $past(!byte_valid) && $past(!byte_stall) |-> !byte_stall)
        else $error("input stalled with empty pipeline");

endmodule

bind decimal_integer_list_parser dilp_checker u_dilp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
